/* hw/rtl/khrg_pkg.sv */
// ----------------------------------------------------------------------------
// khrg_pkg
// Types, constants and the microcode program of the keyed hash random gate.
// ----------------------------------------------------------------------------
package khrg_pkg;

  localparam logic [63:0] FNV_BASIS  = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME  = 64'h00000100000001b3;
  localparam logic [63:0] MIX_INC    = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL2   = 64'h94d049bb133111eb;
  localparam logic [63:0] STREAM_KEY = 64'h632be59bd9b4e019;

  localparam int unsigned PcW = 5;

  localparam logic [PcW-1:0] PC_BYTE  = 5'd0;   // multiply by FNV prime
  localparam logic [PcW-1:0] PC_MIX   = 5'd3;   // stream key, then mixing
  localparam logic [PcW-1:0] PC_LAST  = 5'd26;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_MUL0,    // p = al * kl
    UOP_MUL1,    // p += (al * kh) << 32
    UOP_MUL2,    // acc = p + (ah * kl) << 32
    UOP_LDSTR,   // acc = stream + STREAM_KEY
    UOP_ADDINC,  // acc += MIX_INC
    UOP_XS30,
    UOP_XS27,
    UOP_XS31,
    UOP_KEY,     // acc = seed ^ hash ^ acc
    UOP_SCALE,   // p = al * bound, hash back to basis
    UOP_OUT      // load output word
  } uop_e;

  typedef enum logic [1:0] {
    K_PRIME,
    K_MUL1,
    K_MUL2
  } ksel_e;

  typedef struct packed {
    uop_e  op;
    ksel_e ksel;
    logic  wr_hash;
    logic  fin_nl;   // finish here unless the word is marked last
    logic  fin;
  } cw_t;

  function automatic logic [63:0] kconst(ksel_e k);
    logic [63:0] v;
    case (k)
      K_PRIME: v = FNV_PRIME;
      K_MUL1:  v = MIX_MUL1;
      K_MUL2:  v = MIX_MUL2;
      default: v = FNV_PRIME;
    endcase
    return v;
  endfunction

  function automatic cw_t mk(uop_e op, ksel_e k, logic wr_hash, logic fin_nl, logic fin);
    cw_t c;
    c.op      = op;
    c.ksel    = k;
    c.wr_hash = wr_hash;
    c.fin_nl  = fin_nl;
    c.fin     = fin;
    return c;
  endfunction

  function automatic cw_t ucode(logic [PcW-1:0] pc);
    cw_t c;
    case (pc)
      5'd0:    c = mk(UOP_MUL0,   K_PRIME, 1'b0, 1'b0, 1'b0);
      5'd1:    c = mk(UOP_MUL1,   K_PRIME, 1'b0, 1'b0, 1'b0);
      5'd2:    c = mk(UOP_MUL2,   K_PRIME, 1'b1, 1'b1, 1'b0);
      5'd3:    c = mk(UOP_LDSTR,  K_PRIME, 1'b0, 1'b0, 1'b0);
      5'd4:    c = mk(UOP_ADDINC, K_PRIME, 1'b0, 1'b0, 1'b0);
      5'd5:    c = mk(UOP_XS30,   K_PRIME, 1'b0, 1'b0, 1'b0);
      5'd6:    c = mk(UOP_MUL0,   K_MUL1,  1'b0, 1'b0, 1'b0);
      5'd7:    c = mk(UOP_MUL1,   K_MUL1,  1'b0, 1'b0, 1'b0);
      5'd8:    c = mk(UOP_MUL2,   K_MUL1,  1'b0, 1'b0, 1'b0);
      5'd9:    c = mk(UOP_XS27,   K_PRIME, 1'b0, 1'b0, 1'b0);
      5'd10:   c = mk(UOP_MUL0,   K_MUL2,  1'b0, 1'b0, 1'b0);
      5'd11:   c = mk(UOP_MUL1,   K_MUL2,  1'b0, 1'b0, 1'b0);
      5'd12:   c = mk(UOP_MUL2,   K_MUL2,  1'b0, 1'b0, 1'b0);
      5'd13:   c = mk(UOP_XS31,   K_PRIME, 1'b0, 1'b0, 1'b0);
      5'd14:   c = mk(UOP_KEY,    K_PRIME, 1'b0, 1'b0, 1'b0);
      5'd15:   c = mk(UOP_ADDINC, K_PRIME, 1'b0, 1'b0, 1'b0);
      5'd16:   c = mk(UOP_XS30,   K_PRIME, 1'b0, 1'b0, 1'b0);
      5'd17:   c = mk(UOP_MUL0,   K_MUL1,  1'b0, 1'b0, 1'b0);
      5'd18:   c = mk(UOP_MUL1,   K_MUL1,  1'b0, 1'b0, 1'b0);
      5'd19:   c = mk(UOP_MUL2,   K_MUL1,  1'b0, 1'b0, 1'b0);
      5'd20:   c = mk(UOP_XS27,   K_PRIME, 1'b0, 1'b0, 1'b0);
      5'd21:   c = mk(UOP_MUL0,   K_MUL2,  1'b0, 1'b0, 1'b0);
      5'd22:   c = mk(UOP_MUL1,   K_MUL2,  1'b0, 1'b0, 1'b0);
      5'd23:   c = mk(UOP_MUL2,   K_MUL2,  1'b0, 1'b0, 1'b0);
      5'd24:   c = mk(UOP_XS31,   K_PRIME, 1'b0, 1'b0, 1'b0);
      5'd25:   c = mk(UOP_SCALE,  K_PRIME, 1'b0, 1'b0, 1'b0);
      5'd26:   c = mk(UOP_OUT,    K_PRIME, 1'b0, 1'b0, 1'b1);
      default: c = mk(UOP_NOP,    K_PRIME, 1'b0, 1'b0, 1'b1);
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/keyed_hash_random_gate.sv */
// ----------------------------------------------------------------------------
// keyed_hash_random_gate
// FNV-1a over identifier bytes, keyed splitmix64 finish, scaled value and
// gate flag. Microcoded sequencer around one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  in       | in        | in_valid_i / in_ready_o | id_byte, has_byte, last,
//           |           |                        | stream_index, bound, threshold
//  out      | out       | out_valid_o/out_ready_i | raw_value, scaled_value, passes
//  cfg      | in        | cfg_we_i                | cfg_wdata_i (seed)
//
//  Byte word without last: three partial products of the prime.
//  Byte word with last: the prime product, then the keyed finish; empty last word: the finish only; idle word: no work.
//  The cost is set by the single 32x32 multiplier, three passes per 64-bit
//  product, four such products in the splitmix64 finish plus the scale.
//  Reset: hash to the FNV offset basis, seed to 0, no word pending.
//  A pending output word stalls only the final step; input waits until idle.
// ----------------------------------------------------------------------------
module keyed_hash_random_gate
  import khrg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  id_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  input  logic [7:0]  stream_index_i,
  input  logic [31:0] bound_i,
  input  logic [31:0] threshold_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] raw_value_o,
  output logic [31:0] scaled_value_o,
  output logic        passes_o
);

  logic [63:0]    seed_q;
  logic [63:0]    hash_q, hash_d;
  logic [63:0]    acc_q, acc_d;
  logic [63:0]    p_q, p_d;
  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic           last_q;
  logic [7:0]     stream_q;
  logic [31:0]    bound_q;
  logic [31:0]    thr_q;
  logic           out_valid_q, out_valid_d;
  logic [63:0]    raw_q;
  logic [31:0]    scaled_q;
  logic           passes_q;

  cw_t         cw;
  logic        accept;
  logic        stall;
  logic        exec;
  logic [63:0] k;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] prod_sh;

  assign cw      = ucode(pc_q);
  assign accept  = in_valid_i & in_ready_o;
  assign stall   = (cw.op == UOP_OUT) & out_valid_q & ~out_ready_i;
  assign exec    = busy_q & ~stall;
  assign k       = kconst(cw.ksel);
  assign mul_a   = (cw.op == UOP_MUL2) ? acc_q[63:32] : acc_q[31:0];
  assign mul_b   = (cw.op == UOP_SCALE) ? bound_q :
                   (cw.op == UOP_MUL1) ? k[63:32] : k[31:0];
  assign prod    = {32'd0, mul_a} * {32'd0, mul_b};
  assign prod_sh = {prod[31:0], 32'd0};

  always_comb begin
    acc_d       = acc_q;
    p_d         = p_q;
    hash_d      = hash_q;
    busy_d      = busy_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    if (accept) begin
      if (has_byte_i) begin
        acc_d  = hash_q ^ {56'd0, id_byte_i};
        busy_d = 1'b1;
        pc_d   = PC_BYTE;
      end else if (last_i) begin
        busy_d = 1'b1;
        pc_d   = PC_MIX;
      end
    end

    if (exec) begin
      case (cw.op)
        UOP_MUL0:   p_d   = prod;
        UOP_MUL1:   p_d   = p_q + prod_sh;
        UOP_MUL2:   acc_d = p_q + prod_sh;
        UOP_LDSTR:  acc_d = {56'd0, stream_q} + STREAM_KEY;
        UOP_ADDINC: acc_d = acc_q + MIX_INC;
        UOP_XS30:   acc_d = acc_q ^ (acc_q >> 30);
        UOP_XS27:   acc_d = acc_q ^ (acc_q >> 27);
        UOP_XS31:   acc_d = acc_q ^ (acc_q >> 31);
        UOP_KEY:    acc_d = seed_q ^ hash_q ^ acc_q;
        UOP_SCALE: begin
          p_d    = prod;
          hash_d = FNV_BASIS;
        end
        UOP_OUT:    out_valid_d = 1'b1;
        default:    ;
      endcase
      if (cw.wr_hash) begin
        hash_d = acc_d;
      end
      if (cw.fin || (cw.fin_nl && !last_q)) begin
        busy_d = 1'b0;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      hash_q      <= FNV_BASIS;
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      hash_q      <= hash_d;
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    p_q   <= p_d;
    if (accept) begin
      last_q   <= last_i;
      stream_q <= stream_index_i;
      bound_q  <= bound_i;
      thr_q    <= threshold_i;
    end
    if (exec && cw.op == UOP_OUT) begin
      raw_q    <= acc_q;
      scaled_q <= p_q[63:32];
      passes_q <= (p_q[63:32] < thr_q);
    end
  end

  assign in_ready_o     = ~busy_q;
  assign out_valid_o    = out_valid_q;
  assign raw_value_o    = raw_q;
  assign scaled_value_o = scaled_q;
  assign passes_o       = passes_q;

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (has_byte_i || last_i) |=> busy_q)
    else $error("sequencer did not start on a working word");

  a_pc_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pc_q <= PC_LAST)
    else $error("step counter beyond program");

  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(exec && cw.op == UOP_OUT))
    else $error("output word raised outside the output step");

  a_hash_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cw.op == UOP_OUT |-> hash_q == FNV_BASIS)
    else $error("running hash not back at offset basis");

endmodule
